// ===== sv/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Types and constants shared by the control surface command mixer and its
// checker: request and result layouts, request codes, register indexes and
// per-surface tables.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_STICK    = 2'd0,
    REQ_TRIM     = 2'd1,
    REQ_THROTTLE = 2'd2,
    REQ_RESET    = 2'd3
  } req_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 15;
  localparam logic [CfgIdxW-1:0] CFG_AILERON_LIMIT       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ELEVATOR_LIMIT      = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DISENGAGE_THRESHOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_THROTTLE_DEADBAND   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_MOTOR_OFFSET   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_MOTOR_OFFSET  = 3'd5;

  // register reset values
  localparam logic [6:0]         AILERON_LIMIT_RST   = 7'd70;
  localparam logic [6:0]         ELEVATOR_LIMIT_RST  = 7'd45;
  localparam logic [14:0]        DISENGAGE_RST       = 15'd4915;
  localparam logic [14:0]        DEADBAND_RST        = 15'd1147;

  // surfaces: left aileron, right aileron, left elevator, right elevator
  localparam int unsigned NumSurf = 4;
  localparam logic [NumSurf-1:0][7:0] NEUTRAL_TAB = {8'd70, 8'd90, 8'd90, 8'd90};
  localparam logic [NumSurf-1:0]      DIR_NEG_TAB = 4'b1011;

  // limits
  localparam logic signed [12:0] TRIM_MAX   = 13'sd2880;
  localparam logic [7:0]         ANGLE_MAX  = 8'd180;
  localparam logic signed [27:0] PULSE_LO_Q = 28'sd16384000;
  localparam logic signed [27:0] PULSE_HI_Q = 28'sd32768000;
  localparam logic signed [27:0] PULSE_BASE = 28'sd1000;
  localparam logic [10:0]        PULSE_MIN  = 11'd1000;
  localparam logic [10:0]        PULSE_MAX  = 11'd2000;

  // one command request
  typedef struct packed {
    req_e               req_type;
    logic signed [15:0] roll_stick;
    logic signed [15:0] pitch_stick;
    logic               trim_axis;
    logic signed [11:0] trim_delta;
    logic signed [15:0] throttle_level;
  } cmd_t;

  // one result
  typedef struct packed {
    logic [7:0]  left_aileron_angle;
    logic [7:0]  right_aileron_angle;
    logic [7:0]  left_elevator_angle;
    logic [7:0]  right_elevator_angle;
    logic [10:0] left_motor_pulse;
    logic [10:0] right_motor_pulse;
    logic        disengage_autopilot;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/control_surface_command_mixer.sv =====
// ----------------------------------------------------------------------------
// control_surface_command_mixer
// Mixes radio commands into four servo angles, two motor pulses and an
// autopilot disengage flag, keeping trims, last angles and throttle level.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while the result side keeps up. The
// request register is loaded at acceptance and the result register when that
// request fires, so the result is driven from the result register. Throughput
// is one request per cycle as long as the result side keeps up.
// The figure is set by the combinational mixing path between the request
// register and the result register, which also updates the trim, angle and
// throttle state as the result is registered, so the next request sees it at once. When
// the result is not taken, one more request is still accepted into the
// request register before ready drops. Configuration writes take effect on
// the following cycle and should be issued only while the block is idle.
`default_nettype none

module control_surface_command_mixer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_we_i,
  input  wire logic [csm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [csm_pkg::CfgDataW-1:0] cfg_wdata_i,
  // requests
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire csm_pkg::cmd_t             in_data_i,
  // results
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output csm_pkg::result_t               out_data_o
);
  import csm_pkg::*;

  // surface angle from stick term and trim
  function automatic logic [7:0] surf_angle(logic signed [23:0] angle_q,
                                            logic signed [12:0] trim,
                                            logic [6:0] limit,
                                            logic [7:0] neutral,
                                            logic dir_neg);
    logic signed [24:0] t;
    logic signed [24:0] lim;
    logic signed [24:0] v;
    logic [10:0]        deg;
    t   = {angle_q[23], angle_q} + {{2{trim[12]}}, trim, 10'b0};
    lim = {4'b0, limit, 14'b0};
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    v = {3'b0, neutral, 14'b0};
    if (dir_neg) v = v - t;
    else v = v + t;
    if (v <= 25'sd0) begin
      deg = 11'd0;
    end else begin
      deg = v[24:14];
      if (deg > {3'b0, ANGLE_MAX}) deg = {3'b0, ANGLE_MAX};
    end
    return deg[7:0];
  endfunction

  // saturating trim update
  function automatic logic signed [12:0] trim_add(logic signed [12:0] trim,
                                                  logic signed [11:0] delta,
                                                  logic dir_neg);
    logic signed [13:0] d;
    logic signed [13:0] s;
    d = {{2{delta[11]}}, delta};
    s = {trim[12], trim} + (dir_neg ? -d : d);
    if (s > $signed({TRIM_MAX[12], TRIM_MAX})) s = {TRIM_MAX[12], TRIM_MAX};
    if (s < -$signed({TRIM_MAX[12], TRIM_MAX})) s = -$signed({TRIM_MAX[12], TRIM_MAX});
    return s[12:0];
  endfunction

  // motor pulse from offset and held throttle
  function automatic logic [10:0] motor_pulse(logic signed [10:0] offset,
                                              logic signed [15:0] held);
    logic signed [27:0] base;
    logic signed [27:0] prod;
    logic signed [27:0] v;
    base = $signed({{17{offset[10]}}, offset}) + PULSE_BASE;
    prod = $signed({{12{held[15]}}, held}) * PULSE_BASE;
    v    = $signed({base[13:0], 14'b0}) + prod;
    if (v < PULSE_LO_Q) v = PULSE_LO_Q;
    if (v > PULSE_HI_Q) v = PULSE_HI_Q;
    return v[24:14];
  endfunction

  // configuration registers
  logic [6:0]         ail_limit_q;
  logic [6:0]         elev_limit_q;
  logic [14:0]        disengage_q;
  logic [14:0]        deadband_q;
  logic signed [10:0] left_offset_q;
  logic signed [10:0] right_offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ail_limit_q    <= AILERON_LIMIT_RST;
      elev_limit_q   <= ELEVATOR_LIMIT_RST;
      disengage_q    <= DISENGAGE_RST;
      deadband_q     <= DEADBAND_RST;
      left_offset_q  <= '0;
      right_offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AILERON_LIMIT:       ail_limit_q    <= cfg_wdata_i[6:0];
        CFG_ELEVATOR_LIMIT:      elev_limit_q   <= cfg_wdata_i[6:0];
        CFG_DISENGAGE_THRESHOLD: disengage_q    <= cfg_wdata_i;
        CFG_THROTTLE_DEADBAND:   deadband_q     <= cfg_wdata_i;
        CFG_LEFT_MOTOR_OFFSET:   left_offset_q  <= cfg_wdata_i[10:0];
        CFG_RIGHT_MOTOR_OFFSET:  right_offset_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_valid_q;
  cmd_t cmd_q;
  logic out_valid_q;
  result_t result_q;
  logic advance;
  logic fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= in_data_i;
    end
  end

  // state
  logic signed [NumSurf-1:0][12:0] trim_q, trim_d;
  logic [NumSurf-1:0][7:0]         angle_q, angle_d;
  logic signed [15:0]              throttle_q, throttle_d;

  // stick products and disengage check
  logic signed [23:0] ail_prod;
  logic signed [23:0] elev_prod;
  logic [16:0]        roll_mag;
  logic [16:0]        pitch_mag;
  logic               disengage;

  assign ail_prod  = 24'(cmd_q.roll_stick) * 24'($signed({1'b0, ail_limit_q}));
  assign elev_prod = 24'(cmd_q.pitch_stick) * 24'($signed({1'b0, elev_limit_q}));
  assign roll_mag  = cmd_q.roll_stick[15] ?
                     (17'd0 - {cmd_q.roll_stick[15], cmd_q.roll_stick}) :
                     {1'b0, cmd_q.roll_stick};
  assign pitch_mag = cmd_q.pitch_stick[15] ?
                     (17'd0 - {cmd_q.pitch_stick[15], cmd_q.pitch_stick}) :
                     {1'b0, cmd_q.pitch_stick};
  assign disengage = (cmd_q.req_type == REQ_STICK) &&
                     ((roll_mag > {2'b0, disengage_q}) ||
                      (pitch_mag > {2'b0, disengage_q}));

  // per-surface trim and angle update
  always_comb begin
    logic               is_ail;
    logic               moves;
    logic signed [23:0] stick_q;
    for (int s = 0; s < NumSurf; s++) begin
      is_ail  = (s < 2);
      stick_q = '0;
      moves   = 1'b0;
      trim_d[s] = trim_q[s];
      case (cmd_q.req_type)
        REQ_STICK: begin
          moves   = 1'b1;
          stick_q = is_ail ? ail_prod : elev_prod;
        end
        REQ_TRIM: begin
          if (cmd_q.trim_axis == !is_ail) begin
            moves     = 1'b1;
            trim_d[s] = trim_add(trim_q[s], cmd_q.trim_delta, DIR_NEG_TAB[s]);
          end
        end
        REQ_RESET: begin
          moves     = 1'b1;
          trim_d[s] = '0;
        end
        default: ;
      endcase
      angle_d[s] = moves ?
                   surf_angle(stick_q, trim_d[s], is_ail ? ail_limit_q : elev_limit_q,
                              NEUTRAL_TAB[s], DIR_NEG_TAB[s]) :
                   angle_q[s];
    end
  end

  // throttle with deadband
  always_comb begin
    throttle_d = throttle_q;
    if (cmd_q.req_type == REQ_THROTTLE) begin
      throttle_d = (cmd_q.throttle_level < $signed({1'b0, deadband_q})) ?
                   16'sd0 : cmd_q.throttle_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q     <= '0;
      angle_q    <= NEUTRAL_TAB;
      throttle_q <= '0;
    end else if (fire) begin
      trim_q     <= trim_d;
      angle_q    <= angle_d;
      throttle_q <= throttle_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q.left_aileron_angle   <= angle_d[0];
      result_q.right_aileron_angle  <= angle_d[1];
      result_q.left_elevator_angle  <= angle_d[2];
      result_q.right_elevator_angle <= angle_d[3];
      result_q.left_motor_pulse     <= motor_pulse(left_offset_q, throttle_d);
      result_q.right_motor_pulse    <= motor_pulse(right_offset_q, throttle_d);
      result_q.disengage_autopilot  <= disengage;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = result_q;

endmodule

`default_nettype wire

// ===== sv/csm_checker.sv =====
// ----------------------------------------------------------------------------
// csm_checker
// Port-level checks on the control surface command mixer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire csm_pkg::result_t out_data_o
);
  import csm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // request side stalls only behind a waiting result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request stalled without a waiting result");

  // motor pulses stay in range
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.left_motor_pulse >= PULSE_MIN &&
                    out_data_o.left_motor_pulse <= PULSE_MAX &&
                    out_data_o.right_motor_pulse >= PULSE_MIN &&
                    out_data_o.right_motor_pulse <= PULSE_MAX)
    else $error("motor pulse out of range");

  // servo angles stay in range
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.left_aileron_angle <= ANGLE_MAX &&
                    out_data_o.right_aileron_angle <= ANGLE_MAX &&
                    out_data_o.left_elevator_angle <= ANGLE_MAX &&
                    out_data_o.right_elevator_angle <= ANGLE_MAX)
    else $error("servo angle out of range");

endmodule

bind control_surface_command_mixer csm_checker u_csm_checker (.*);

`default_nettype wire
